@@ rtl/lut_pkg.sv @@
`default_nettype none

package lut_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned DEPTH  = 64;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned STEP_W = 5;

	localparam logic [CNT_W-1:0]  MIN_ENTRIES   = 7'd4;
	localparam logic [CNT_W-1:0]  MAX_ENTRIES   = 7'd64;
	localparam logic [CNT_W-1:0]  RESET_ENTRIES = 7'd64;
	localparam logic [DATA_W-1:0] DATA_MAX      = 16'hFFFF;

	// opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FWD   = 2'd1;
	localparam logic [1:0] OP_INV   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BELOW = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [DATA_W-1:0] entry_key;
		logic [DATA_W-1:0] entry_value;
		logic [DATA_W-1:0] query_point;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] answer;
		logic [1:0]        status;
		logic [IDX_W-1:0]  segment;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_RD0,
		S_RD1,
		S_RD2,
		S_MUL,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

@@ rtl/lut_tbl.sv @@
`default_nettype none

module lut_tbl (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [lut_pkg::IDX_W-1:0]  waddr,
	input  wire logic [lut_pkg::DATA_W-1:0] wdata,
	input  wire logic [lut_pkg::IDX_W-1:0]  raddr,
	output logic      [lut_pkg::DATA_W-1:0] rdata
);

	logic [lut_pkg::DATA_W-1:0] mem_q [lut_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/lut_div.sv @@
`default_nettype none

module lut_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lut_pkg::PROD_W-1:0] dividend,
	input  wire logic [lut_pkg::DATA_W-1:0] divisor,
	output logic                            done,
	output logic      [lut_pkg::PROD_W-1:0] quotient
);

	logic                        run_q;
	logic [lut_pkg::STEP_W-1:0]  cnt_q;
	logic [lut_pkg::DATA_W-1:0]  rem_q;
	logic [lut_pkg::DATA_W-1:0]  dvs_q;
	logic [lut_pkg::PROD_W-1:0]  quo_q;
	logic                        done_q;
	logic [lut_pkg::DATA_W:0]    trial;
	logic [lut_pkg::DATA_W:0]    diff;
	logic                        ge;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[lut_pkg::PROD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {lut_pkg::STEP_W{1'b1}}) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[lut_pkg::DATA_W-1:0] : trial[lut_pkg::DATA_W-1:0];
			quo_q <= {quo_q[lut_pkg::PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/lut_piecewise_linear_lookup_unit.sv @@
// One-dimensional piecewise-linear lookup over a 64-entry key table and value
// table of unsigned 16-bit entries. A write word (opcode write) stores key and
// value at entry_index and is done in its accept cycle: busy stays low and no
// result appears. A forward lookup searches the key table and answers from the
// value table; an inverse lookup swaps them. The search walks the first n
// entries (n = entries_in_use clamped to 4..64) through the table memory's
// single registered read port, one entry per cycle, and keeps the last entry at
// or below the query; the segment is clamped to n-2. The two segment ends are
// then read, one multiply forms dy*dx, and a restoring divider produces one
// quotient bit per cycle. A lookup skips the divide when the segment ends are
// equal, and ends after the first compare when the query lies below entry 0.
// busy is high from accept until the result; the result shows for exactly one
// cycle with done high and cannot be held off, so the receiver must take it
// then. Config writes are always ready and should only be issued while busy
// is low. Table contents after reset are undefined until written.
`default_nettype none

module lut_piecewise_linear_lookup_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command side
	input  wire logic                       start,
	input  wire lut_pkg::req_t              req,
	output logic                            busy,
	// result side
	output logic                            done,
	output lut_pkg::rsp_t                   rsp,
	// config: entries_in_use
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [lut_pkg::CNT_W-1:0]  cfg_data
);

	localparam int unsigned DW = lut_pkg::DATA_W;
	localparam int unsigned IW = lut_pkg::IDX_W;
	localparam int unsigned CW = lut_pkg::CNT_W;
	localparam int unsigned PW = lut_pkg::PROD_W;

	lut_pkg::state_t state_q, state_d;

	logic [CW-1:0] eiu_q;      // entries_in_use register
	logic [CW-1:0] n_q;        // clamped entry count for this lookup
	logic [IW-1:0] cnt_q;      // scan position of the word on the read port
	logic [IW-1:0] idx_q;      // last entry found at or below the query
	logic [IW-1:0] seg_q;
	logic          inv_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [PW-1:0] prod_q;
	logic [DW-1:0] add_q;
	logic          neg_q;
	logic          done_q;
	lut_pkg::rsp_t rsp_q;

	logic          accept;
	logic          lookup_go;
	logic          wr_en;
	logic [CW-1:0] n_clamp;
	logic [IW-1:0] rd_addr;
	logic [DW-1:0] kd, vd, xs_d, ys_d;
	logic          scan_le, scan_last;
	logic [IW-1:0] idx_fin, seg_fin;
	logic [CW-1:0] nm2;

	// arithmetic on the segment
	logic          eq_ends;
	logic          neg_dy, neg_dx, neg_dd;
	logic [DW-1:0] ady, adx, add;
	logic [DW:0]   avg_sum;
	logic          div_start, div_done;
	logic [PW-1:0] div_quo;
	logic          sat;
	logic [DW-1:0] fin_ans;

	assign accept    = start && !busy;
	assign lookup_go = accept && (req.opcode == lut_pkg::OP_FWD || req.opcode == lut_pkg::OP_INV);
	assign wr_en     = accept && (req.opcode == lut_pkg::OP_WRITE);
	assign cfg_ready = 1'b1;
	assign busy      = (state_q != lut_pkg::S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;

	// clamp entry count to 4..64
	assign n_clamp = (eiu_q < lut_pkg::MIN_ENTRIES) ? lut_pkg::MIN_ENTRIES :
	                 (eiu_q > lut_pkg::MAX_ENTRIES) ? lut_pkg::MAX_ENTRIES : eiu_q;

	// key and value tables share write and read addresses
	lut_tbl u_key_tbl (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req.entry_index),
		.wdata (req.entry_key),
		.raddr (rd_addr),
		.rdata (kd)
	);

	lut_tbl u_val_tbl (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req.entry_index),
		.wdata (req.entry_value),
		.raddr (rd_addr),
		.rdata (vd)
	);

	// searched table and answer table, swapped for inverse lookup
	assign xs_d = inv_q ? vd : kd;
	assign ys_d = inv_q ? kd : vd;

	// scan compare and segment clamp
	assign scan_le   = (xs_d <= x_q);
	assign scan_last = ({1'b0, cnt_q} == (n_q - 1'b1));
	assign idx_fin   = scan_le ? cnt_q : idx_q;
	assign nm2       = n_q - 7'd2;
	assign seg_fin   = ({1'b0, idx_fin} > nm2) ? nm2[IW-1:0] : idx_fin;

	// segment differences as sign and magnitude
	assign eq_ends = (x1_q == x2_q);
	assign neg_dy  = (y2_q < y1_q);
	assign neg_dx  = (x_q < x1_q);
	assign neg_dd  = (x2_q < x1_q);
	assign ady     = neg_dy ? (y1_q - y2_q) : (y2_q - y1_q);
	assign adx     = neg_dx ? (x1_q - x_q)  : (x_q - x1_q);
	assign add     = neg_dd ? (x1_q - x2_q) : (x2_q - x1_q);
	assign avg_sum = {1'b0, y1_q} + {1'b0, y2_q};

	lut_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (add_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturate y1 +/- quotient
	always_comb begin
		if (neg_q) begin
			sat     = div_quo > {{(PW-DW){1'b0}}, y1_q};
			fin_ans = sat ? '0 : (y1_q - div_quo[DW-1:0]);
		end else begin
			sat     = div_quo > {{(PW-DW){1'b0}}, (lut_pkg::DATA_MAX - y1_q)};
			fin_ans = sat ? lut_pkg::DATA_MAX : (y1_q + div_quo[DW-1:0]);
		end
	end

	// sequencer: next state, read address, divider start
	always_comb begin
		state_d   = state_q;
		rd_addr   = seg_q;
		div_start = 1'b0;
		unique case (state_q)
			lut_pkg::S_IDLE: begin
				rd_addr = '0;
				if (lookup_go) begin
					state_d = lut_pkg::S_SCAN;
				end
			end
			lut_pkg::S_SCAN: begin
				rd_addr = cnt_q + 1'b1;
				if (cnt_q == '0 && !scan_le) begin
					state_d = lut_pkg::S_IDLE;
				end else if (scan_last) begin
					state_d = lut_pkg::S_RD0;
				end
			end
			lut_pkg::S_RD0: begin
				rd_addr = seg_q;
				state_d = lut_pkg::S_RD1;
			end
			lut_pkg::S_RD1: begin
				rd_addr = seg_q + 1'b1;
				state_d = lut_pkg::S_RD2;
			end
			lut_pkg::S_RD2: begin
				state_d = lut_pkg::S_MUL;
			end
			lut_pkg::S_MUL: begin
				state_d = eq_ends ? lut_pkg::S_IDLE : lut_pkg::S_PREP;
			end
			lut_pkg::S_PREP: begin
				div_start = 1'b1;
				state_d   = lut_pkg::S_DIV;
			end
			lut_pkg::S_DIV: begin
				if (div_done) begin
					state_d = lut_pkg::S_FIN;
				end
			end
			lut_pkg::S_FIN: begin
				state_d = lut_pkg::S_IDLE;
			end
			default: begin
				state_d = lut_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lut_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q  <= lut_pkg::RESET_ENTRIES;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				eiu_q <= cfg_data;
			end
			done_q <= 1'b0;
			if (lookup_go) begin
				cnt_q <= '0;
			end else if (state_q == lut_pkg::S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == lut_pkg::S_SCAN && cnt_q == '0 && !scan_le) begin
				done_q <= 1'b1;
			end
			if (state_q == lut_pkg::S_MUL && eq_ends) begin
				done_q <= 1'b1;
			end
			if (state_q == lut_pkg::S_FIN) begin
				done_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			x_q   <= req.query_point;
			inv_q <= (req.opcode == lut_pkg::OP_INV);
			n_q   <= n_clamp;
			idx_q <= '0;
		end
		case (state_q)
			lut_pkg::S_SCAN: begin
				idx_q <= idx_fin;
				seg_q <= seg_fin;
				if (cnt_q == '0 && !scan_le) begin
					rsp_q.answer  <= '0;
					rsp_q.status  <= lut_pkg::ST_BELOW;
					rsp_q.segment <= '0;
				end
			end
			lut_pkg::S_RD1: begin
				x1_q <= xs_d;
				y1_q <= ys_d;
			end
			lut_pkg::S_RD2: begin
				x2_q <= xs_d;
				y2_q <= ys_d;
			end
			lut_pkg::S_MUL: begin
				prod_q <= ady * adx;
				add_q  <= add;
				neg_q  <= (neg_dy != neg_dx) != neg_dd;
				if (eq_ends) begin
					rsp_q.answer  <= avg_sum[DW:1];
					rsp_q.status  <= lut_pkg::ST_OK;
					rsp_q.segment <= seg_q;
				end
			end
			lut_pkg::S_FIN: begin
				rsp_q.answer  <= fin_ans;
				rsp_q.status  <= sat ? lut_pkg::ST_SAT : lut_pkg::ST_OK;
				rsp_q.segment <= seg_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/lut_chk.sv @@
`default_nettype none

module lut_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire lut_pkg::req_t             req,
	input wire logic                      busy,
	input wire logic                      done,
	input wire lut_pkg::rsp_t             rsp
);

	// a result only follows a lookup in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a lookup in flight");

	// results are never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// a write finishes in its accept cycle
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.opcode == lut_pkg::OP_WRITE) |=> (!busy && !done))
		else $error("write word kept the block busy or produced a result");

	// a lookup occupies the block
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.opcode == lut_pkg::OP_FWD || req.opcode == lut_pkg::OP_INV))
		|=> (busy && !done))
		else $error("lookup accepted without going busy");

	// below-range result carries zero answer and segment
	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == lut_pkg::ST_BELOW) |-> (rsp.answer == '0 && rsp.segment == '0))
		else $error("below-range result with nonzero answer or segment");

endmodule

bind lut_piecewise_linear_lookup_unit lut_chk u_lut_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.req       (req),
	.busy      (busy),
	.done      (done),
	.rsp       (rsp)
);

`default_nettype wire
